@@ rtl/core/touch_map_and_grid_hit_test_defines.svh @@
// assertion macros used by the touch mapper checker
`ifndef TOUCH_MAP_AND_GRID_HIT_TEST_DEFINES_SVH
`define TOUCH_MAP_AND_GRID_HIT_TEST_DEFINES_SVH

// same-cycle implication, clocked on i_clk, off while i_rst_n is low
`define TMG_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on i_clk, off while i_rst_n is low
`define TMG_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/tmg_pkg.sv @@
// types, constants and codes of the touch mapper and grid hit tester
package tmg_pkg;

    // screen, grid and button geometry
    localparam int SCREEN_W       = 320;
    localparam int SCREEN_H       = 240;
    localparam int GRID_STEPS     = 16;
    localparam int GRID_TRACKS    = 6;
    localparam int BTN_HEIGHT     = 25;
    localparam int BPM_BTN_WIDTH  = 30;
    localparam int PLAY_BTN_WIDTH = 60;
    localparam int PRESS_MIN      = 10;
    localparam int PRESS_MAX      = 1000;

    // field widths
    localparam int RAW_W       = 10;
    localparam int GOX_W       = 9;
    localparam int GOY_W       = 8;
    localparam int CW_W        = 9;
    localparam int CH_W        = 8;
    localparam int COORD_W     = 12;
    localparam int ACT_W       = 3;
    localparam int STEP_IDX_W  = $clog2(GRID_STEPS);
    localparam int TRACK_IDX_W = $clog2(GRID_TRACKS);
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 10;

    // divider widths: quotient magnitude, divisor, signed mapped value
    localparam int QUO_W = $clog2(((2 ** RAW_W) - 1) * SCREEN_W + 1);
    localparam int DEN_W = RAW_W;
    localparam int SX_W  = QUO_W + 1;
    localparam int NUM_W = SX_W;
    localparam int REL_W = QUO_W;

    localparam logic signed [SX_W-1:0] SX_SAT_HI = SX_W'((2 ** (COORD_W - 1)) - 1);
    localparam logic signed [SX_W-1:0] SX_SAT_LO = SX_W'(-(2 ** (COORD_W - 1)));

    typedef enum logic [ACT_W-1:0] {
        ACT_NONE     = 3'd0,
        ACT_GRID     = 3'd1,
        ACT_BPM_UP   = 3'd2,
        ACT_BPM_DOWN = 3'd3,
        ACT_PLAY     = 3'd4
    } t_action;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CAL_MIN_X     = 3'd0,
        CFG_CAL_MAX_X     = 3'd1,
        CFG_CAL_MIN_Y     = 3'd2,
        CFG_CAL_MAX_Y     = 3'd3,
        CFG_GRID_ORIGIN_X = 3'd4,
        CFG_GRID_ORIGIN_Y = 3'd5,
        CFG_CELL_WIDTH    = 3'd6,
        CFG_CELL_HEIGHT   = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic [RAW_W-1:0] raw_x;
        logic [RAW_W-1:0] raw_y;
        logic [RAW_W-1:0] pressure;
    } t_in_item;

    typedef struct packed {
        logic [ACT_W-1:0]         action_kind;
        logic [TRACK_IDX_W-1:0]   track_index;
        logic [STEP_IDX_W-1:0]    step_index;
        logic signed [COORD_W-1:0] screen_x;
        logic signed [COORD_W-1:0] screen_y;
        logic                     touch_valid;
    } t_out_item;

    typedef struct packed {
        logic [RAW_W-1:0] cal_min_x;
        logic [RAW_W-1:0] cal_max_x;
        logic [RAW_W-1:0] cal_min_y;
        logic [RAW_W-1:0] cal_max_y;
        logic [GOX_W-1:0] grid_origin_x;
        logic [GOY_W-1:0] grid_origin_y;
        logic [CW_W-1:0]  cell_width;
        logic [CH_W-1:0]  cell_height;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        cal_min_x:     RAW_W'(150),
        cal_max_x:     RAW_W'(920),
        cal_min_y:     RAW_W'(120),
        cal_max_y:     RAW_W'(940),
        grid_origin_x: GOX_W'(10),
        grid_origin_y: GOY_W'(40),
        cell_width:    CW_W'(16),
        cell_height:   CH_W'(24)
    };

    // one coordinate in flight through the divider
    typedef struct packed {
        logic [DEN_W-1:0] rem;
        logic [QUO_W-1:0] nq;
        logic [DEN_W-1:0] dv;
        logic             neg;
        logic             zero;
    } t_lane;

    typedef struct packed {
        t_lane x;
        t_lane y;
        logic  touch_valid;
    } t_div_word;

endpackage

@@ rtl/core/tmg_front.sv @@
// input stage: calibration offset, span scaling, sign split and validity
module tmg_front import tmg_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_adv,
    input  logic      i_valid,
    input  t_in_item  i_data,
    input  t_cfg      i_cfg,
    output logic      o_valid,
    output t_div_word o_word
);

    logic      r_valid;
    t_div_word r_word;
    t_div_word n_word;

    function automatic t_lane lane_init(
        input logic [RAW_W-1:0] raw,
        input logic [RAW_W-1:0] lo,
        input logic [RAW_W-1:0] hi,
        input int               span
    );
        logic signed [NUM_W-1:0] diff;
        logic signed [NUM_W-1:0] den;
        logic signed [NUM_W-1:0] num;
        logic [NUM_W-1:0]        mag;
        t_lane                   l;
        diff   = $signed(NUM_W'(raw)) - $signed(NUM_W'(lo));
        den    = $signed(NUM_W'(hi)) - $signed(NUM_W'(lo));
        num    = diff * $signed(NUM_W'(span));
        mag    = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
        l.rem  = '0;
        l.nq   = mag[QUO_W-1:0];
        l.dv   = den[NUM_W-1] ? DEN_W'(-den) : DEN_W'(den);
        l.neg  = num[NUM_W-1] ^ den[NUM_W-1];
        l.zero = (den == '0);
        return l;
    endfunction

    always_comb begin
        n_word.x = lane_init(i_data.raw_x, i_cfg.cal_min_x, i_cfg.cal_max_x, SCREEN_W);
        n_word.y = lane_init(i_data.raw_y, i_cfg.cal_min_y, i_cfg.cal_max_y, SCREEN_H);
        n_word.touch_valid = (i_data.pressure >= RAW_W'(PRESS_MIN)) &&
                             (i_data.pressure <= RAW_W'(PRESS_MAX)) &&
                             (i_data.raw_x >= i_cfg.cal_min_x) &&
                             (i_data.raw_x <= i_cfg.cal_max_x) &&
                             (i_data.raw_y >= i_cfg.cal_min_y) &&
                             (i_data.raw_y <= i_cfg.cal_max_y);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_word <= n_word;
        end
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;

endmodule

@@ rtl/core/tmg_divider.sv @@
// pipelined restoring divider, one quotient bit per stage, x and y lanes side by side
module tmg_divider import tmg_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_adv,
    input  logic      i_valid,
    input  t_div_word i_word,
    output logic      o_valid,
    output t_div_word o_word
);

    logic [QUO_W-1:0] r_valid;
    t_div_word        r_word [QUO_W];
    t_div_word        n_word [QUO_W];

    function automatic t_lane div_step(input t_lane a);
        logic [DEN_W:0] t;
        logic           ge;
        t_lane          b;
        b     = a;
        t     = {a.rem, a.nq[QUO_W-1]};
        ge    = (t >= {1'b0, a.dv});
        b.rem = ge ? DEN_W'(t - {1'b0, a.dv}) : t[DEN_W-1:0];
        b.nq  = {a.nq[QUO_W-2:0], ge};
        return b;
    endfunction

    function automatic t_div_word word_step(input t_div_word w);
        t_div_word v;
        v   = w;
        v.x = div_step(w.x);
        v.y = div_step(w.y);
        return v;
    endfunction

    always_comb begin
        n_word[0] = word_step(i_word);
        for (int i = 1; i < QUO_W; i++) begin
            n_word[i] = word_step(r_word[i-1]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_adv) begin
            r_valid <= {r_valid[QUO_W-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            for (int i = 0; i < QUO_W; i++) begin
                r_word[i] <= n_word[i];
            end
        end
    end

    assign o_valid = r_valid[QUO_W-1];
    assign o_word  = r_word[QUO_W-1];

endmodule

@@ rtl/core/tmg_hit.sv @@
// sign fix-up, saturation, grid hit test and button decode in four stages
module tmg_hit import tmg_pkg::*; #(
    parameter int STEP_GAP      = 2,
    parameter int TRACK_GAP     = 2,
    parameter int CONTROL_ROW_Y = 200,
    parameter int BPM_UP_LEFT   = 10,
    parameter int BPM_DOWN_LEFT = 50,
    parameter int PLAY_LEFT     = 100
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_adv,
    input  logic      i_valid,
    input  t_div_word i_word,
    input  t_cfg      i_cfg,
    output logic      o_valid,
    output t_out_item o_item
);

    localparam int PX_W = $clog2((2 ** CW_W) + STEP_GAP);
    localparam int PY_W = $clog2((2 ** CH_W) + TRACK_GAP);
    localparam int MX_W = PX_W + STEP_IDX_W;
    localparam int MY_W = PY_W + TRACK_IDX_W;
    localparam int CX_W = (REL_W > MX_W) ? REL_W : MX_W;
    localparam int CY_W = (REL_W > MY_W) ? REL_W : MY_W;

    localparam logic signed [SX_W-1:0] ROW_LO  = SX_W'(CONTROL_ROW_Y);
    localparam logic signed [SX_W-1:0] ROW_HI  = SX_W'(CONTROL_ROW_Y + BTN_HEIGHT);
    localparam logic signed [SX_W-1:0] UP_LO   = SX_W'(BPM_UP_LEFT);
    localparam logic signed [SX_W-1:0] UP_HI   = SX_W'(BPM_UP_LEFT + BPM_BTN_WIDTH);
    localparam logic signed [SX_W-1:0] DN_LO   = SX_W'(BPM_DOWN_LEFT);
    localparam logic signed [SX_W-1:0] DN_HI   = SX_W'(BPM_DOWN_LEFT + BPM_BTN_WIDTH);
    localparam logic signed [SX_W-1:0] PLAY_LO = SX_W'(PLAY_LEFT);
    localparam logic signed [SX_W-1:0] PLAY_HI = SX_W'(PLAY_LEFT + PLAY_BTN_WIDTH);

    typedef struct packed {
        logic signed [SX_W-1:0] sx;
        logic signed [SX_W-1:0] sy;
        logic                   tv;
    } t_h1;

    typedef struct packed {
        logic [REL_W-1:0]          rel_x;
        logic [REL_W-1:0]          rel_y;
        logic                      ge_x;
        logic                      ge_y;
        t_action                   btn;
        logic signed [COORD_W-1:0] sat_x;
        logic signed [COORD_W-1:0] sat_y;
        logic                      tv;
    } t_h2;

    typedef struct packed {
        logic [REL_W-1:0]          rel_x;
        logic [REL_W-1:0]          rel_y;
        logic [STEP_IDX_W-1:0]     s;
        logic [TRACK_IDX_W-1:0]    t;
        logic                      in_x;
        logic                      in_y;
        t_action                   btn;
        logic signed [COORD_W-1:0] sat_x;
        logic signed [COORD_W-1:0] sat_y;
        logic                      tv;
    } t_h3;

    logic [3:0] r_valid;
    t_h1        r_s1, n_s1;
    t_h2        r_s2, n_s2;
    t_h3        r_s3, n_s3;
    t_out_item  r_s4, n_s4;

    logic [PX_W-1:0] pitch_x;
    logic [PY_W-1:0] pitch_y;

    function automatic logic signed [SX_W-1:0] apply_sign(input t_lane l);
        logic signed [SX_W-1:0] q;
        q = $signed({1'b0, l.nq});
        if (l.zero) begin
            return '0;
        end
        return l.neg ? -q : q;
    endfunction

    function automatic logic signed [COORD_W-1:0] sat12(input logic signed [SX_W-1:0] v);
        if (v > SX_SAT_HI) begin
            return SX_SAT_HI[COORD_W-1:0];
        end
        if (v < SX_SAT_LO) begin
            return SX_SAT_LO[COORD_W-1:0];
        end
        return v[COORD_W-1:0];
    endfunction

    assign pitch_x = PX_W'(i_cfg.cell_width) + PX_W'(STEP_GAP);
    assign pitch_y = PY_W'(i_cfg.cell_height) + PY_W'(TRACK_GAP);

    // stage 1: signed quotient
    always_comb begin
        n_s1.sx = apply_sign(i_word.x);
        n_s1.sy = apply_sign(i_word.y);
        n_s1.tv = i_word.touch_valid;
    end

    // stage 2: grid-relative offsets, button row, saturation
    always_comb begin
        logic signed [SX_W-1:0] gox;
        logic signed [SX_W-1:0] goy;
        logic signed [SX_W-1:0] dx;
        logic signed [SX_W-1:0] dy;
        logic                   in_row;
        gox        = $signed(SX_W'(i_cfg.grid_origin_x));
        goy        = $signed(SX_W'(i_cfg.grid_origin_y));
        dx         = r_s1.sx - gox;
        dy         = r_s1.sy - goy;
        n_s2.ge_x  = (r_s1.sx >= gox);
        n_s2.ge_y  = (r_s1.sy >= goy);
        n_s2.rel_x = dx[REL_W-1:0];
        n_s2.rel_y = dy[REL_W-1:0];
        in_row     = (r_s1.sy >= ROW_LO) && (r_s1.sy <= ROW_HI);
        if (in_row && (r_s1.sx >= UP_LO) && (r_s1.sx <= UP_HI)) begin
            n_s2.btn = ACT_BPM_UP;
        end else if (in_row && (r_s1.sx >= DN_LO) && (r_s1.sx <= DN_HI)) begin
            n_s2.btn = ACT_BPM_DOWN;
        end else if (in_row && (r_s1.sx >= PLAY_LO) && (r_s1.sx <= PLAY_HI)) begin
            n_s2.btn = ACT_PLAY;
        end else begin
            n_s2.btn = ACT_NONE;
        end
        n_s2.sat_x = sat12(r_s1.sx);
        n_s2.sat_y = sat12(r_s1.sy);
        n_s2.tv    = r_s1.tv;
    end

    // stage 3: cell index by comparing against pitch multiples
    always_comb begin
        logic [STEP_IDX_W-1:0]  cnt_s;
        logic [TRACK_IDX_W-1:0] cnt_t;
        cnt_s = '0;
        cnt_t = '0;
        for (int k = 1; k < GRID_STEPS; k++) begin
            if (CX_W'(r_s2.rel_x) >= CX_W'(MX_W'(k) * MX_W'(pitch_x))) begin
                cnt_s = cnt_s + STEP_IDX_W'(1);
            end
        end
        for (int k = 1; k < GRID_TRACKS; k++) begin
            if (CY_W'(r_s2.rel_y) >= CY_W'(MY_W'(k) * MY_W'(pitch_y))) begin
                cnt_t = cnt_t + TRACK_IDX_W'(1);
            end
        end
        n_s3.rel_x = r_s2.rel_x;
        n_s3.rel_y = r_s2.rel_y;
        n_s3.s     = cnt_s;
        n_s3.t     = cnt_t;
        n_s3.in_x  = r_s2.ge_x && (pitch_x != '0) &&
                     (CX_W'(r_s2.rel_x) < CX_W'(MX_W'(GRID_STEPS) * MX_W'(pitch_x)));
        n_s3.in_y  = r_s2.ge_y && (pitch_y != '0) &&
                     (CY_W'(r_s2.rel_y) < CY_W'(MY_W'(GRID_TRACKS) * MY_W'(pitch_y)));
        n_s3.btn   = r_s2.btn;
        n_s3.sat_x = r_s2.sat_x;
        n_s3.sat_y = r_s2.sat_y;
        n_s3.tv    = r_s2.tv;
    end

    // stage 4: reject the gap after each cell, pick the action
    always_comb begin
        logic [CX_W-1:0] rem_x;
        logic [CY_W-1:0] rem_y;
        logic            grid_hit;
        rem_x    = CX_W'(r_s3.rel_x) - CX_W'(MX_W'(r_s3.s) * MX_W'(pitch_x));
        rem_y    = CY_W'(r_s3.rel_y) - CY_W'(MY_W'(r_s3.t) * MY_W'(pitch_y));
        grid_hit = r_s3.in_x && r_s3.in_y &&
                   (rem_x < CX_W'(i_cfg.cell_width)) &&
                   (rem_y < CY_W'(i_cfg.cell_height));
        if (grid_hit) begin
            n_s4.action_kind = ACT_GRID;
            n_s4.track_index = r_s3.t;
            n_s4.step_index  = r_s3.s;
        end else begin
            n_s4.action_kind = r_s3.btn;
            n_s4.track_index = '0;
            n_s4.step_index  = '0;
        end
        n_s4.screen_x    = r_s3.sat_x;
        n_s4.screen_y    = r_s3.sat_y;
        n_s4.touch_valid = r_s3.tv;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_adv) begin
            r_valid <= {r_valid[2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_s1 <= n_s1;
            r_s2 <= n_s2;
            r_s3 <= n_s3;
            r_s4 <= n_s4;
        end
    end

    assign o_valid = r_valid[3];
    assign o_item  = r_s4;

endmodule

@@ rtl/core/touch_map_and_grid_hit_test.sv @@
// touch sample mapper and grid hit tester, top level
// path: a beat accepted on the sample channel reaches o_valid through
//   1 front stage, 19 divider stages, 4 hit-test stages and 1 output register
// throughput: one beat per cycle while no waiting result holds the pipeline
// reset: synchronous active-low i_rst_n empties the pipeline and loads the
//   calibration and grid registers with their defaults
module touch_map_and_grid_hit_test import tmg_pkg::*; #(
    parameter int STEP_GAP      = 2,
    parameter int TRACK_GAP     = 2,
    parameter int CONTROL_ROW_Y = 200,
    parameter int BPM_UP_LEFT   = 10,
    parameter int BPM_DOWN_LEFT = 50,
    parameter int PLAY_LEFT     = 100
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // sample channel
    input  logic                  i_valid,
    output logic                  o_ready,
    input  t_in_item              i_data,
    // result channel
    output logic                  o_valid,
    input  logic                  i_ready,
    output t_out_item             o_data,
    // register write port
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    // calibration and grid geometry registers
    t_cfg r_cfg;

    // pipeline hand-offs
    logic      front_valid;
    t_div_word front_word;
    logic      div_valid;
    t_div_word div_word;
    logic      hit_valid;
    t_out_item hit_item;

    // output register
    logic      r_out_valid;
    t_out_item r_out_data;

    logic adv;
    logic out_load;

    // the whole pipeline moves together; it only holds when the output
    // register is occupied and not taken while the last hit stage has a
    // beat to hand over, so bubbles squeeze out behind a waiting result
    assign out_load = !r_out_valid || i_ready;
    assign adv      = !(r_out_valid && !i_ready && hit_valid);
    assign o_ready  = adv;

    // register writes, one per cycle, no read-back
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_CAL_MIN_X:     r_cfg.cal_min_x     <= i_cfg_data[RAW_W-1:0];
                CFG_CAL_MAX_X:     r_cfg.cal_max_x     <= i_cfg_data[RAW_W-1:0];
                CFG_CAL_MIN_Y:     r_cfg.cal_min_y     <= i_cfg_data[RAW_W-1:0];
                CFG_CAL_MAX_Y:     r_cfg.cal_max_y     <= i_cfg_data[RAW_W-1:0];
                CFG_GRID_ORIGIN_X: r_cfg.grid_origin_x <= i_cfg_data[GOX_W-1:0];
                CFG_GRID_ORIGIN_Y: r_cfg.grid_origin_y <= i_cfg_data[GOY_W-1:0];
                CFG_CELL_WIDTH:    r_cfg.cell_width    <= i_cfg_data[CW_W-1:0];
                CFG_CELL_HEIGHT:   r_cfg.cell_height   <= i_cfg_data[CH_W-1:0];
                default: ;
            endcase
        end
    end

    // offset from the calibration minimum, times the screen span, split
    // into magnitude and sign for the divider
    tmg_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_valid (i_valid),
        .i_data  (i_data),
        .i_cfg   (r_cfg),
        .o_valid (front_valid),
        .o_word  (front_word)
    );

    // truncating division by the calibration window width, both axes at once
    tmg_divider u_divider (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_valid (front_valid),
        .i_word  (front_word),
        .o_valid (div_valid),
        .o_word  (div_word)
    );

    // grid cells first, then the control buttons; the hit test sees the
    // exact mapped point and only the reported coordinates saturate
    tmg_hit #(
        .STEP_GAP      (STEP_GAP),
        .TRACK_GAP     (TRACK_GAP),
        .CONTROL_ROW_Y (CONTROL_ROW_Y),
        .BPM_UP_LEFT   (BPM_UP_LEFT),
        .BPM_DOWN_LEFT (BPM_DOWN_LEFT),
        .PLAY_LEFT     (PLAY_LEFT)
    ) u_hit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_valid (div_valid),
        .i_word  (div_word),
        .i_cfg   (r_cfg),
        .o_valid (hit_valid),
        .o_item  (hit_item)
    );

    // output register parts the result channel from the pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= hit_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_data <= hit_item;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out_data;

endmodule

@@ rtl/core/tmg_checker.sv @@
// port-level checker for the touch mapper and its bind to the top level
`include "touch_map_and_grid_hit_test_defines.svh"

module tmg_checker import tmg_pkg::*; #(
    parameter int CONTROL_ROW_Y = 200
) (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_valid,
    input logic      i_ready,
    input t_out_item o_data
);

    logic out_stall;
    logic is_grid;
    logic is_btn;
    logic idx_zero;
    logic track_ok;
    logic in_row;
    int   scr_y;

    assign out_stall = o_valid && !i_ready;
    assign is_grid   = (o_data.action_kind == ACT_GRID);
    assign is_btn    = (o_data.action_kind == ACT_BPM_UP) ||
                       (o_data.action_kind == ACT_BPM_DOWN) ||
                       (o_data.action_kind == ACT_PLAY);
    assign idx_zero  = (o_data.track_index == '0) && (o_data.step_index == '0);
    assign track_ok  = (o_data.track_index < TRACK_IDX_W'(GRID_TRACKS));
    assign scr_y     = int'($signed(o_data.screen_y));
    assign in_row    = (scr_y >= CONTROL_ROW_Y) && (scr_y <= CONTROL_ROW_Y + BTN_HEIGHT);

    // a stalled result beat holds
    `TMG_ASSERT_NEXT(a_out_hold, out_stall, o_valid && $stable(o_data), "stalled beat changed")

    // cell indexes are only reported on a grid hit
    `TMG_ASSERT_NOW(a_idx_zero, o_valid && !is_grid, idx_zero, "cell index without grid hit")

    // a grid hit never names a track past the last one
    `TMG_ASSERT_NOW(a_track_range, o_valid && is_grid, track_ok, "track index out of range")

    // buttons only fire inside the control row
    `TMG_ASSERT_NOW(a_btn_row, o_valid && is_btn, in_row, "button hit outside control row")

endmodule

bind touch_map_and_grid_hit_test tmg_checker #(
    .CONTROL_ROW_Y (CONTROL_ROW_Y)
) u_tmg_checker (.*);
